### rtl/swurd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swurd_pkg
// Shared types, codes and the crc-8 helper for the register datagram master.
// ----------------------------------------------------------------------------
package swurd_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] SyncByte       = 8'h05;
  localparam logic [7:0] CrcPoly        = 8'h07;
  localparam logic [7:0] WriteFlag      = 8'h80;
  localparam logic [7:0] ReadMask       = 8'h7F;
  localparam logic [7:0] TimeoutReset   = 8'd35;
  localparam logic [7:0] CountMax       = 8'd255;
  localparam logic [7:0] MaxNode        = 8'd3;
  localparam logic [3:0] ReplyLen       = 4'd8;
  localparam logic [3:0] ReplyDataFirst = 4'd3;
  localparam logic [3:0] ReplyDataLast  = 4'd6;
  localparam logic [2:0] WriteLastIdx   = 3'd7;
  localparam logic [2:0] ReadLastIdx    = 3'd3;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_RX    = 3'd2,
    OP_TICK  = 3'd3,
    OP_FERR  = 3'd4,
    OP_OERR  = 3'd5,
    OP_STATS = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STATS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_RESULT,
    CMD_STATS
  } cmd_e;

  // data carries the write word, the read value, or both counters
  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  node;
    logic [7:0]  reg_byte;
    logic [31:0] data;
    logic        ok;
  } cmd_t;

  // crc-8, byte fed lsb first
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ b[k];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

### rtl/swurd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swurd_front
// Accepts input transactions, tracks the pending read and error counters,
// and queues one command per transaction that yields output.
// ----------------------------------------------------------------------------
module swurd_front
  import swurd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  node_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  logic [7:0]  timeout_q, timeout_d;
  logic        pending_q, pending_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  idle_q, idle_d;
  logic [31:0] word_q, word_d;
  logic [7:0]  ferr_q, ferr_d;
  logic [7:0]  oerr_q, oerr_d;

  logic [1:0]  node;
  logic [7:0]  idle_inc;
  logic [3:0]  count_inc;
  logic [31:0] word_next;

  assign node      = (node_addr_i > MaxNode) ? MaxNode[1:0] : node_addr_i[1:0];
  assign idle_inc  = (idle_q != CountMax) ? idle_q + 8'd1 : idle_q;
  assign count_inc = count_q + 4'd1;
  assign word_next = (count_q >= ReplyDataFirst && count_q <= ReplyDataLast) ?
                     {word_q[23:0], rx_byte_i} : word_q;

  always_comb begin
    timeout_d = cfg_we_i ? cfg_wdata_i : timeout_q;
    pending_d = pending_q;
    count_d   = count_q;
    idle_d    = idle_q;
    word_d    = word_q;
    ferr_d    = ferr_q;
    oerr_d    = oerr_q;
    push_o    = 1'b0;
    push_cmd_o.cmd      = CMD_RESULT;
    push_cmd_o.node     = node;
    push_cmd_o.reg_byte = reg_addr_i | WriteFlag;
    push_cmd_o.data     = '0;
    push_cmd_o.ok       = 1'b0;
    if (accept_i) begin
      unique case (op_e'(op_i))
        OP_WRITE: begin
          if (!pending_q) begin
            push_o          = 1'b1;
            push_cmd_o.cmd  = CMD_WRITE;
            push_cmd_o.data = write_data_i;
          end
        end
        OP_READ: begin
          if (!pending_q) begin
            push_o              = 1'b1;
            push_cmd_o.cmd      = CMD_READ;
            push_cmd_o.reg_byte = reg_addr_i & ReadMask;
            pending_d           = 1'b1;
            count_d             = '0;
            idle_d              = '0;
            word_d              = '0;
          end
        end
        OP_RX: begin
          if (pending_q) begin
            idle_d  = '0;
            count_d = count_inc;
            word_d  = word_next;
            if (count_inc >= ReplyLen) begin
              push_o          = 1'b1;
              push_cmd_o.data = word_next;
              push_cmd_o.ok   = 1'b1;
              pending_d       = 1'b0;
              count_d         = '0;
              word_d          = '0;
            end
          end
        end
        OP_TICK: begin
          if (pending_q) begin
            idle_d = idle_inc;
            if (idle_inc >= timeout_q) begin
              push_o    = 1'b1;
              pending_d = 1'b0;
              count_d   = '0;
              idle_d    = '0;
              word_d    = '0;
            end
          end
        end
        OP_FERR, OP_OERR: begin
          if (pending_q) begin
            if (op_e'(op_i) == OP_FERR) begin
              ferr_d = (ferr_q != CountMax) ? ferr_q + 8'd1 : ferr_q;
            end else begin
              oerr_d = (oerr_q != CountMax) ? oerr_q + 8'd1 : oerr_q;
            end
            push_o    = 1'b1;
            pending_d = 1'b0;
            count_d   = '0;
            idle_d    = '0;
            word_d    = '0;
          end
        end
        OP_STATS: begin
          push_o          = 1'b1;
          push_cmd_o.cmd  = CMD_STATS;
          push_cmd_o.data = {16'd0, ferr_q, oerr_q};
          ferr_d          = '0;
          oerr_d          = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      pending_q <= 1'b0;
      count_q   <= '0;
      idle_q    <= '0;
      word_q    <= '0;
      ferr_q    <= '0;
      oerr_q    <= '0;
    end else begin
      timeout_q <= timeout_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      idle_q    <= idle_d;
      word_q    <= word_d;
      ferr_q    <= ferr_d;
      oerr_q    <= oerr_d;
    end
  end

  // a read only ends by queueing its result
  a_read_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pending_q) |-> $past(push_o) && $past(push_cmd_o.cmd) == CMD_RESULT)
    else $error("read ended without a queued result");

  // reply byte and idle counts stay cleared while no read is pending
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> count_q == 4'd0 && idle_q == 8'd0)
    else $error("reply tracking not cleared while idle");

endmodule

### rtl/swurd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swurd_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module swurd_queue
  import swurd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == DepthCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");

endmodule

### rtl/swurd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swurd_back
// Expands the command at the queue head into output transactions, one per
// cycle while the output is not stalled, building the datagram crc on the fly.
// ----------------------------------------------------------------------------
module swurd_back
  import swurd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [31:0] read_value_o,
  output logic        read_ok_o,
  output logic [7:0]  framing_count_o,
  output logic [7:0]  overrun_count_o
);

  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  logic        valid_q, valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic [31:0] value_q, value_d;
  logic        ok_q, ok_d;
  logic [7:0]  fc_q, fc_d;
  logic [7:0]  oc_q, oc_d;

  logic       load;
  logic       is_dgram;
  logic       dgram_last;
  logic [7:0] sel_byte;

  assign load     = !empty_i && (!valid_q || !out_stall_i);
  assign is_dgram = (head_i.cmd == CMD_WRITE) || (head_i.cmd == CMD_READ);
  assign dgram_last = (head_i.cmd == CMD_WRITE) ? (idx_q == WriteLastIdx) :
                                                 (idx_q == ReadLastIdx);

  always_comb begin
    case (idx_q)
      3'd0:    sel_byte = SyncByte;
      3'd1:    sel_byte = {6'd0, head_i.node};
      3'd2:    sel_byte = head_i.reg_byte;
      3'd3:    sel_byte = head_i.data[31:24];
      3'd4:    sel_byte = head_i.data[23:16];
      3'd5:    sel_byte = head_i.data[15:8];
      default: sel_byte = head_i.data[7:0];
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    pop_o   = 1'b0;
    valid_d = (valid_q && out_stall_i) || load;
    kind_d  = kind_q;
    tx_d    = tx_q;
    last_d  = last_q;
    value_d = value_q;
    ok_d    = ok_q;
    fc_d    = fc_q;
    oc_d    = oc_q;
    if (load) begin
      tx_d    = '0;
      last_d  = 1'b0;
      value_d = '0;
      ok_d    = 1'b0;
      fc_d    = '0;
      oc_d    = '0;
      if (is_dgram) begin
        kind_d = KIND_TX;
        tx_d   = dgram_last ? crc_q : sel_byte;
        last_d = dgram_last;
        if (dgram_last) begin
          pop_o = 1'b1;
          idx_d = '0;
          crc_d = '0;
        end else begin
          idx_d = idx_q + 3'd1;
          crc_d = crc8_byte(crc_q, sel_byte);
        end
      end else if (head_i.cmd == CMD_RESULT) begin
        kind_d  = KIND_READ;
        value_d = head_i.data;
        ok_d    = head_i.ok;
        pop_o   = 1'b1;
      end else begin
        kind_d = KIND_STATS;
        fc_d   = head_i.data[15:8];
        oc_d   = head_i.data[7:0];
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    tx_q    <= tx_d;
    last_q  <= last_d;
    value_q <= value_d;
    ok_q    <= ok_d;
    fc_q    <= fc_d;
    oc_q    <= oc_d;
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign tx_byte_o       = tx_q;
  assign last_o          = last_q;
  assign read_value_o    = value_q;
  assign read_ok_o       = ok_q;
  assign framing_count_o = fc_q;
  assign overrun_count_o = oc_q;

  // mid-datagram the command stays at the queue head
  a_idx_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> !empty_i && is_dgram)
    else $error("datagram position without a datagram command");

  a_crc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q == 3'd0 |-> crc_q == 8'd0)
    else $error("crc not cleared at datagram start");

endmodule

### rtl/single_wire_uart_register_datagram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_uart_register_datagram
// Master side of a single-wire uart register protocol with crc-8 datagrams.
// ----------------------------------------------------------------------------
// One input transaction is taken per cycle while the command queue
// (QueueDepth entries) has room; requests, reply bytes, ticks and errors are
// resolved at acceptance. The output register then delivers one transaction
// per cycle while out_stall_i is low: a write request gives eight transmit
// bytes, a read request four, and a read result or stats report one, so a
// stream of write requests is paced by the output stage.
// ----------------------------------------------------------------------------
module single_wire_uart_register_datagram
  import swurd_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  node_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [31:0] read_value_o,
  output logic        read_ok_o,
  output logic [7:0]  framing_count_o,
  output logic [7:0]  overrun_count_o
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  swurd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .op_i         (op_i),
    .node_addr_i  (node_addr_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  swurd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  swurd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o),
    .read_value_o    (read_value_o),
    .read_ok_o       (read_ok_o),
    .framing_count_o (framing_count_o),
    .overrun_count_o (overrun_count_o)
  );

endmodule
